// ===== rtl/hist2_pkg.sv =====
// Shared constants and types of the weighted two-dimensional histogram.
`default_nettype none

package hist2_pkg;

	// Store geometry
	localparam int MAX_BINS_X = 64;
	localparam int MAX_BINS_Y = 64;
	localparam int DEPTH      = MAX_BINS_X * MAX_BINS_Y;
	localparam int ADDR_W     = $clog2(DEPTH);

	// Bin counting: CNT_W holds a count up to the larger limit, BIN_W a bin index
	localparam int MAX_BIN_LIMIT = (MAX_BINS_X > MAX_BINS_Y) ? MAX_BINS_X : MAX_BINS_Y;
	localparam int CNT_W         = $clog2(MAX_BIN_LIMIT + 1);
	localparam int BIN_W         = (MAX_BIN_LIMIT > 1) ? $clog2(MAX_BIN_LIMIT) : 1;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int VALUE_W  = 32;
	localparam int IDX_W    = 6;
	localparam int RAW_CNT_W = 7;

	// Request kinds
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_MIN_X  = 3'd0;
	localparam logic [2:0] CFG_MAX_X  = 3'd1;
	localparam logic [2:0] CFG_MIN_Y  = 3'd2;
	localparam logic [2:0] CFG_MAX_Y  = 3'd3;
	localparam logic [2:0] CFG_BINS_X = 3'd4;
	localparam logic [2:0] CFG_BINS_Y = 3'd5;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] min_x;
		logic signed [SAMPLE_W-1:0] max_x;
		logic signed [SAMPLE_W-1:0] min_y;
		logic signed [SAMPLE_W-1:0] max_y;
		logic [CNT_W-1:0]           nx;
		logic [CNT_W-1:0]           ny;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic             ok;
		logic [BIN_W-1:0] bin;
	} map_res_t;

endpackage

`default_nettype wire

// ===== rtl/hist2_cfg.sv =====
// Configuration registers with effective bin counts.
`default_nettype none

module hist2_cfg
	import hist2_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [2:0]          wr_index,
	input  wire logic [SAMPLE_W-1:0] wr_data,
	output cfg_t                     cfg
);

	logic signed [SAMPLE_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [RAW_CNT_W-1:0]       bins_x_q, bins_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q  <= '0;
			max_x_q  <= SAMPLE_W'(16'sd32767);
			min_y_q  <= '0;
			max_y_q  <= SAMPLE_W'(16'sd32767);
			bins_x_q <= RAW_CNT_W'(64);
			bins_y_q <= RAW_CNT_W'(64);
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MIN_X:  min_x_q  <= wr_data;
				CFG_MAX_X:  max_x_q  <= wr_data;
				CFG_MIN_Y:  min_y_q  <= wr_data;
				CFG_MAX_Y:  max_y_q  <= wr_data;
				CFG_BINS_X: bins_x_q <= wr_data[RAW_CNT_W-1:0];
				CFG_BINS_Y: bins_y_q <= wr_data[RAW_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Treat a zero count as one and clamp to the store size
	always_comb begin
		cfg.min_x = min_x_q;
		cfg.max_x = max_x_q;
		cfg.min_y = min_y_q;
		cfg.max_y = max_y_q;
		if (bins_x_q == '0)
			cfg.nx = CNT_W'(1);
		else if (32'(bins_x_q) > MAX_BINS_X)
			cfg.nx = CNT_W'(MAX_BINS_X);
		else
			cfg.nx = CNT_W'(bins_x_q);
		if (bins_y_q == '0)
			cfg.ny = CNT_W'(1);
		else if (32'(bins_y_q) > MAX_BINS_Y)
			cfg.ny = CNT_W'(MAX_BINS_Y);
		else
			cfg.ny = CNT_W'(bins_y_q);
	end

endmodule

`default_nettype wire

// ===== rtl/hist2_bin_map.sv =====
// One axis: range check, scale by bin count and bit-serial divide by the range width.
`default_nettype none

module hist2_bin_map
	import hist2_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic signed [SAMPLE_W-1:0] lo,
	input  wire logic signed [SAMPLE_W-1:0] hi,
	input  wire logic [CNT_W-1:0]           count,
	output map_res_t                        res
);

	localparam int PROD_W = CNT_W + SAMPLE_W;
	localparam int STEP_W = $clog2(CNT_W + 1);

	logic [SAMPLE_W-1:0] off_q, span_q;
	logic [CNT_W-1:0]    n_q, quo_q;
	logic                ok_q, zero_q;
	logic [PROD_W-1:0]   rem_q, dvs_q;
	logic                load_q, run_q, done_q;
	logic [STEP_W-1:0]   step_q;

	logic [SAMPLE_W:0]   off_w, span_w;
	logic                fits;

	assign off_w  = {sample[SAMPLE_W-1], sample} - {lo[SAMPLE_W-1], lo};
	assign span_w = {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};
	assign fits   = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			ok_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				load_q <= 1'b1;
				ok_q   <= (sample >= lo) && (sample <= hi);
			end else if (load_q) begin
				load_q <= 1'b0;
				run_q  <= 1'b1;
				step_q <= STEP_W'(CNT_W);
			end else if (run_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: latch operands, form n*off, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			off_q  <= off_w[SAMPLE_W-1:0];
			span_q <= span_w[SAMPLE_W-1:0];
			zero_q <= span_w == '0;
			n_q    <= count;
		end else if (load_q) begin
			rem_q <= PROD_W'(n_q) * PROD_W'(off_q);
			dvs_q <= PROD_W'(span_q) << (CNT_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (fits)
				rem_q <= rem_q - dvs_q;
			quo_q <= {quo_q[CNT_W-2:0], fits};
			dvs_q <= dvs_q >> 1;
		end
	end

	// A sample equal to the top of a range of nonzero width lands in the last bin; a zero-width range maps to bin 0
	always_comb begin
		res.done = done_q;
		res.ok   = ok_q;
		if (zero_q)
			res.bin = '0;
		else if (quo_q >= n_q)
			res.bin = BIN_W'(n_q - CNT_W'(1));
		else
			res.bin = BIN_W'(quo_q);
	end

endmodule

`default_nettype wire

// ===== rtl/hist2_mem.sv =====
// Bin store: single write port, single registered read port.
`default_nettype none

module hist2_mem
	import hist2_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [ADDR_W-1:0]  wr_addr,
	input  wire logic [VALUE_W-1:0] wr_data,
	input  wire logic               rd_en,
	input  wire logic [ADDR_W-1:0]  rd_addr,
	output logic      [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/weighted_2d_histogram.sv =====
// Top level of the weighted two-dimensional histogram.
`default_nettype none

// Weighted 2-D histogram over a 64 x 64 store of 32-bit bins held in one synchronous RAM.
// Each item on the slave stream is a request (tuser = kind): insert adds the weight to the
// bin chosen by x and y, read returns one bin, clear zeroes the store. Each request gives
// exactly one result item on the master stream; a rejected insert returns all zeros.
// Items are handled one at a time. An insert runs the two axis mappers, which divide by the
// range width one quotient bit per cycle (seven steps), before the read-modify-write of the
// bin. A clear sweeps the RAM one word a cycle. After reset the same sweep runs with
// s_axis_tready low; configuration writes are taken throughout. Write configuration only
// while no request is in flight.
module weighted_2d_histogram
	import hist2_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// Request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // sample_x[15:0], sample_y[31:16], weight[47:32],
	                                        // read_col[53:48], read_row[59:54], zero[63:60]
	input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
	// Result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // bin_col[5:0], bin_row[11:6],
	                                        // bin_value[43:12], zero[47:44]
	output logic             m_axis_tuser   // accepted
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_MAP    = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	function automatic logic [ADDR_W-1:0] bin_addr(input logic [7:0] row,
	                                               input logic [7:0] col);
		bin_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_BINS_X) + ADDR_W'(col));
	endfunction

	cfg_t     cfg;
	map_res_t map_x, map_y;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   clr_addr_q, addr_q;
	logic                clr_result_q;

	// Latched request
	logic [1:0]                 req_q;
	logic signed [SAMPLE_W-1:0] x_q, y_q;
	logic [WEIGHT_W-1:0]        w_q;
	logic [IDX_W-1:0]           col_q, row_q;
	logic                       rd_in_q;

	// Output register
	logic                out_valid_q, out_acc_q;
	logic [IDX_W-1:0]    out_col_q, out_row_q;
	logic [VALUE_W-1:0]  out_val_q;

	// RAM ports
	logic                mem_wr_en, mem_rd_en;
	logic [ADDR_W-1:0]   mem_wr_addr, mem_rd_addr;
	logic [VALUE_W-1:0]  mem_wr_data, mem_rd_data;

	logic                s_accept, out_free, out_load, hit;
	logic [1:0]          s_req;
	logic [IDX_W-1:0]    s_col, s_row;
	logic [VALUE_W:0]    sum;
	logic [VALUE_W-1:0]  sat_sum;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = state_q == ST_IDLE;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign s_req         = s_axis_tuser;
	assign s_col         = s_axis_tdata[53:48];
	assign s_row         = s_axis_tdata[59:54];

	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_RESULT) && out_free;
	assign hit      = map_x.ok && map_y.ok;

	// Saturating bin update
	assign sum     = {1'b0, mem_rd_data} + (VALUE_W + 1)'(w_q);
	assign sat_sum = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];

	hist2_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	hist2_bin_map u_map_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_MAP),
		.sample (x_q),
		.lo     (cfg.min_x),
		.hi     (cfg.max_x),
		.count  (cfg.nx),
		.res    (map_x)
	);

	hist2_bin_map u_map_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_MAP),
		.sample (y_q),
		.lo     (cfg.min_y),
		.hi     (cfg.max_y),
		.count  (cfg.ny),
		.res    (map_y)
	);

	hist2_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// RAM access: the sweep owns the write port while clearing; an insert writes back
	// when its result goes to the output register. Reads come from a read request at
	// acceptance or from an insert once both axes have their bin.
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = addr_q;
		mem_wr_data = sat_sum;
		if (state_q == ST_CLEAR) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = clr_addr_q;
			mem_wr_data = '0;
		end else if (out_load && req_q == REQ_INSERT && hit) begin
			mem_wr_en = 1'b1;
		end
	end

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = bin_addr(8'(map_y.bin), 8'(map_x.bin));
		if (s_accept && s_req == REQ_READ) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = bin_addr(8'(s_row), 8'(s_col));
		end else if (state_q == ST_WAIT && map_x.done && hit) begin
			mem_rd_en = 1'b1;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			clr_result_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						// A requested clear owes a result; the reset sweep does not
						state_q      <= clr_result_q ? ST_RESULT : ST_IDLE;
						clr_result_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						case (s_req)
							REQ_INSERT: state_q <= ST_MAP;
							REQ_CLEAR: begin
								state_q      <= ST_CLEAR;
								clr_addr_q   <= '0;
								clr_result_q <= 1'b1;
							end
							default:    state_q <= ST_RESULT;
						endcase
					end
				end
				ST_MAP:    state_q <= ST_WAIT;
				ST_WAIT:   if (map_x.done) state_q <= ST_RESULT;
				ST_RESULT: if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the request fields and the bin address for the write-back
	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_q   <= s_req;
			x_q     <= s_axis_tdata[15:0];
			y_q     <= s_axis_tdata[31:16];
			w_q     <= s_axis_tdata[47:32];
			col_q   <= s_col;
			row_q   <= s_row;
			rd_in_q <= (32'(s_col) < MAX_BINS_X) && (32'(s_row) < MAX_BINS_Y);
		end
		if (state_q == ST_WAIT && map_x.done)
			addr_q <= bin_addr(8'(map_y.bin), 8'(map_x.bin));
	end

	// Output register: filled from the result state, drained by the master side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			case (req_q)
				REQ_INSERT: begin
					out_acc_q <= hit;
					out_col_q <= hit ? IDX_W'(map_x.bin) : '0;
					out_row_q <= hit ? IDX_W'(map_y.bin) : '0;
					out_val_q <= hit ? sat_sum : '0;
				end
				REQ_READ: begin
					out_acc_q <= 1'b1;
					out_col_q <= col_q;
					out_row_q <= row_q;
					out_val_q <= rd_in_q ? mem_rd_data : '0;
				end
				REQ_CLEAR: begin
					out_acc_q <= 1'b1;
					out_col_q <= '0;
					out_row_q <= '0;
					out_val_q <= '0;
				end
				default: begin
					out_acc_q <= 1'b0;
					out_col_q <= '0;
					out_row_q <= '0;
					out_val_q <= '0;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_acc_q;
	assign m_axis_tdata  = {4'b0, out_val_q, out_row_q, out_col_q};

`ifndef NO_ASSERTIONS
	// Both axis mappers run in lock step
	assert property (@(posedge clk) disable iff (!arst_n)
		map_x.done == map_y.done)
		else $error("axis mappers out of step");

	// A mapper finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		map_x.done |-> state_q == ST_WAIT)
		else $error("bin mapping finished outside the wait state");

	// One request at a time: acceptance closes the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_axis_tready)
		else $error("input accepted while a request is in flight");

	// Insert write-back only for an insert that hit a bin
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en && state_q != ST_CLEAR) |-> (req_q == REQ_INSERT && hit))
		else $error("unexpected bin write");

	// A rejected or unknown request carries all-zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
		else $error("rejected result with non-zero data");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/weighted_2d_histogram_test.sv =====
// Self-checking testbench of the weighted two-dimensional histogram: directed and random requests.
module weighted_2d_histogram_test
	import hist2_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// One request item as it travels on the slave stream
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] weight;
		logic [5:0]  col;
		logic [5:0]  row;
	} hist_req_t;

	// One result item as it leaves on the master stream
	typedef struct packed {
		logic        hit;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [31:0] value;
	} hist_res_t;

	// One register write on the configuration channel
	typedef struct packed {
		logic [2:0]  idx;
		logic [15:0] data;
	} reg_write_t;

	// Run limit in ns: a few times a run made entirely of clears
	localparam longint RUN_LIMIT_NS = 200_000_000;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;  // sample_x, sample_y, weight, read_col, read_row, zero
	logic [1:0]  s_axis_tuser  = '0;  // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // bin_col, bin_row, bin_value, zero
	logic        m_axis_tuser;        // accepted

	// Mirror of the block: its configuration and its bin store
	logic signed [15:0] lo_x = 16'sd0;
	logic signed [15:0] hi_x = 16'sd32767;
	logic signed [15:0] lo_y = 16'sd0;
	logic signed [15:0] hi_y = 16'sd32767;
	logic [6:0]         n_x  = 7'd64;
	logic [6:0]         n_y  = 7'd64;
	logic [31:0]        tally [DEPTH];

	// Items waiting to go out, and results the block still owes
	hist_req_t  req_queue [$];
	reg_write_t cfg_queue [$];
	hist_res_t  bin_reports [$];

	int  req_sent, req_taken, cfg_sent, cfg_taken;
	int  mismatches;
	int  n_insert, n_binned, n_saturated, n_read, n_clear, n_none, n_settings;
	bit  steady;  // set: neither side idles

	weighted_2d_histogram dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// Bin count actually in use: zero counts as one, large counts clip to the store
	function automatic int used_bins(input logic [6:0] raw, input int limit);
		if (raw == 0)
			return 1;
		return (raw > limit) ? limit : int'(raw);
	endfunction

	// Map one coordinate onto its axis; false when it falls outside the closed range
	function automatic bit axis_bin(input logic signed [15:0] v, lo, hi,
			input logic [6:0] raw, input int limit, output logic [5:0] bin);
		int span, off, n, b;
		bin = '0;
		if (v < lo || v > hi)
			return 1'b0;
		span = int'(hi) - int'(lo);
		off  = int'(v) - int'(lo);
		n    = used_bins(raw, limit);
		// zero-width range: the single legal value lands in bin 0
		if (span == 0)
			return 1'b1;
		b = (n * off) / span;
		if (b >= n)
			b = n - 1;
		bin = b[5:0];
		return 1'b1;
	endfunction

	// Apply one request to the mirrored store and return the result it must produce
	function automatic hist_res_t bin_update(input hist_req_t r);
		hist_res_t  o;
		logic [5:0] bx, by;
		logic [32:0] sum;
		int         addr;
		o = '0;
		case (r.kind)
			REQ_INSERT: begin
				if (axis_bin(r.x, lo_x, hi_x, n_x, MAX_BINS_X, bx) &&
						axis_bin(r.y, lo_y, hi_y, n_y, MAX_BINS_Y, by)) begin
					addr = int'(by) * MAX_BINS_X + int'(bx);
					sum = {1'b0, tally[addr]} + r.weight;
					// saturate instead of wrapping
					tally[addr] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					o.hit   = 1'b1;
					o.col   = bx;
					o.row   = by;
					o.value = tally[addr];
				end
			end
			REQ_READ: begin
				o.hit = 1'b1;
				o.col = r.col;
				o.row = r.row;
				if (r.col < MAX_BINS_X && r.row < MAX_BINS_Y)
					o.value = tally[int'(r.row) * MAX_BINS_X + int'(r.col)];
			end
			REQ_CLEAR: begin
				foreach (tally[i])
					tally[i] = '0;
				o.hit = 1'b1;
			end
			default: ;
		endcase
		return o;
	endfunction

	// Register write seen by the block: mirror it
	function automatic void apply_cfg(input logic [2:0] idx, input logic [15:0] d);
		case (idx)
			CFG_MIN_X:  lo_x = d;
			CFG_MAX_X:  hi_x = d;
			CFG_MIN_Y:  lo_y = d;
			CFG_MAX_Y:  hi_y = d;
			CFG_BINS_X: n_x  = d[6:0];
			CFG_BINS_Y: n_y  = d[6:0];
			default: ;
		endcase
	endfunction

	// Coordinate mostly inside the range, sometimes on or just past an edge, sometimes anywhere
	function automatic logic [15:0] pick_coord(input logic signed [15:0] lo, hi);
		int          roll;
		logic [15:0] v;
		roll = $urandom_range(99);
		if (roll < 80 && lo <= hi)
			v = 16'(int'(lo) + int'($urandom_range(0, int'(hi) - int'(lo))));
		else if (roll < 92) begin
			case ($urandom_range(3))
				0: v = lo;
				1: v = hi;
				2: v = lo - 16'sd1;
				default: v = hi + 16'sd1;
			endcase
		end else
			v = 16'($urandom);
		return v;
	endfunction

	function automatic hist_req_t random_request();
		hist_req_t r;
		int        roll;
		// noise in every field first; the kind decides which fields matter
		r.x      = 16'($urandom);
		r.y      = 16'($urandom);
		r.weight = 16'($urandom);
		r.col    = 6'($urandom);
		r.row    = 6'($urandom);
		roll = $urandom_range(99);
		if (roll < 70)
			r.kind = REQ_INSERT;
		else if (roll < 93)
			r.kind = REQ_READ;
		else if (roll < 95)
			r.kind = REQ_CLEAR;
		else
			r.kind = REQ_NONE;
		if (r.kind == REQ_INSERT) begin
			r.x = pick_coord(lo_x, hi_x);
			r.y = pick_coord(lo_y, hi_y);
			roll = $urandom_range(99);
			if (roll < 25)
				r.weight = 16'($urandom_range(0, 15));
			else if (roll < 40)
				r.weight = 16'hFFFF;
		end else if (r.kind == REQ_READ && $urandom_range(99) < 75) begin
			// aim reads at the bins in use
			r.col = 6'($urandom_range(0, used_bins(n_x, MAX_BINS_X) - 1));
			r.row = 6'($urandom_range(0, used_bins(n_y, MAX_BINS_Y) - 1));
		end
		return r;
	endfunction

	task automatic push_req(input logic [1:0] kind, input int x, y, w, col, row);
		hist_req_t r;
		r.kind   = kind;
		r.x      = 16'(x);
		r.y      = 16'(y);
		r.weight = 16'(w);
		r.col    = 6'(col);
		r.row    = 6'(row);
		req_queue.insert(req_queue.size(), r);
	endtask

	task automatic push_cfg(input logic [2:0] idx, input int value);
		reg_write_t w;
		w.idx  = idx;
		w.data = 16'(value);
		cfg_queue.insert(cfg_queue.size(), w);
	endtask

	task automatic set_ranges(input int x0, x1, y0, y1, bx, by);
		push_cfg(CFG_MIN_X, x0);
		push_cfg(CFG_MAX_X, x1);
		push_cfg(CFG_MIN_Y, y0);
		push_cfg(CFG_MAX_Y, y1);
		push_cfg(CFG_BINS_X, bx & 'h7F);
		push_cfg(CFG_BINS_Y, by & 'h7F);
		n_settings++;
	endtask

	// Random setting; style 1 keeps the spans narrow, style 2 may invert a range
	task automatic random_setup(input int style);
		int lo [2];
		int hi [2];
		int span, swap;
		for (int a = 0; a < 2; a++) begin
			lo[a] = int'($urandom_range(0, 65535)) - 32768;
			span  = (style == 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
			hi[a] = (lo[a] + span > 32767) ? 32767 : lo[a] + span;
			if (style == 2 && $urandom_range(3) == 0) begin
				swap  = lo[a];
				lo[a] = hi[a];
				hi[a] = swap;
			end
		end
		set_ranges(lo[0], hi[0], lo[1], hi[1], $urandom_range(0, 127), $urandom_range(0, 127));
	endtask

	// Block until every queued item has gone out and every result is back
	task automatic wait_drained();
		@(posedge clk);
		while (req_queue.size() != 0 || req_taken != req_sent || cfg_queue.size() != 0 ||
				cfg_taken != cfg_sent || bin_reports.size() != 0)
			@(posedge clk);
	endtask

	// Drain, then give a trailing insert time to finish before the setting changes
	task automatic drain_and_rest();
		wait_drained();
		repeat (16) @(posedge clk);
	endtask

	// Request driver: hold an item until it is taken, idle now and then between items
	always @(negedge clk) begin
		hist_req_t r;
		if (!s_axis_tvalid || req_taken == req_sent) begin
			if (req_queue.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
				r = req_queue.pop_front();
				s_axis_tdata  <= {4'b0, r.row, r.col, r.weight, r.y, r.x};
				s_axis_tuser  <= r.kind;
				s_axis_tvalid <= 1'b1;
				req_sent++;
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// Configuration driver: same pattern on the register channel
	always @(negedge clk) begin
		reg_write_t w;
		if (!cfg_valid || cfg_taken == cfg_sent) begin
			if (cfg_queue.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
				w = cfg_queue.pop_front();
				cfg_index <= w.idx;
				cfg_data  <= w.data;
				cfg_valid <= 1'b1;
				cfg_sent++;
			end else
				cfg_valid <= 1'b0;
		end
	end

	// Result side back-pressure
	always @(negedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 21);

	// Monitor: check results first, then record newly taken requests and register writes
	always @(posedge clk) begin
		hist_res_t got, want;
		hist_req_t req;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.hit   = m_axis_tuser;
				got.col   = m_axis_tdata[5:0];
				got.row   = m_axis_tdata[11:6];
				got.value = m_axis_tdata[43:12];
				if (bin_reports.size() == 0) begin
					$error("result item with no request outstanding");
					mismatches++;
				end else begin
					want = bin_reports.pop_front();
					if (got.hit !== want.hit) begin
						$error("accepted: expected %0d, got %0d", want.hit, got.hit);
						mismatches++;
					end
					if (got.col !== want.col) begin
						$error("bin_col: expected %0d, got %0d", want.col, got.col);
						mismatches++;
					end
					if (got.row !== want.row) begin
						$error("bin_row: expected %0d, got %0d", want.row, got.row);
						mismatches++;
					end
					if (got.value !== want.value) begin
						$error("bin_value: expected %08h, got %08h", want.value, got.value);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.kind   = s_axis_tuser;
				req.x      = s_axis_tdata[15:0];
				req.y      = s_axis_tdata[31:16];
				req.weight = s_axis_tdata[47:32];
				req.col    = s_axis_tdata[53:48];
				req.row    = s_axis_tdata[59:54];
				want = bin_update(req);
				bin_reports.insert(bin_reports.size(), want);
				case (req.kind)
					REQ_INSERT: begin
						n_insert++;
						if (want.hit)
							n_binned++;
						if (want.hit && want.value == 32'hFFFF_FFFF)
							n_saturated++;
					end
					REQ_READ:  n_read++;
					REQ_CLEAR: n_clear++;
					default:   n_none++;
				endcase
				req_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				apply_cfg(cfg_index, cfg_data);
				cfg_taken++;
			end
		end
	end

	// Watchdog
	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		foreach (tally[i])
			tally[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: edges of a symmetric range, rejects on every side, weight extremes
		set_ranges(-1000, 1000, -8, 8, 10, 5);
		wait_drained();
		push_req(REQ_INSERT, -1000, -8, 1, 0, 0);
		push_req(REQ_INSERT, 1000, 8, 'hFFFF, 0, 0);
		push_req(REQ_INSERT, -1001, 0, 7, 0, 0);
		push_req(REQ_INSERT, 1001, 0, 7, 0, 0);
		push_req(REQ_INSERT, 0, -9, 7, 0, 0);
		push_req(REQ_INSERT, 0, 9, 7, 0, 0);
		push_req(REQ_INSERT, -32768, -32768, 'hFFFF, 63, 63);
		push_req(REQ_INSERT, 32767, 32767, 'hFFFF, 63, 63);
		push_req(REQ_INSERT, 0, 0, 0, 0, 0);
		push_req(REQ_INSERT, 999, 7, 'hABCD, 0, 0);
		push_req(REQ_INSERT, 999, 7, 'hABCD, 0, 0);
		push_req(REQ_READ, 0, 0, 0, 0, 0);
		push_req(REQ_READ, -1, -1, 'hFFFF, 9, 4);
		push_req(REQ_READ, 0, 0, 0, 63, 63);
		push_req(REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
		push_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
		push_req(REQ_READ, 0, 0, 0, 9, 4);
		push_req(REQ_INSERT, 1000, 8, 'hFFFF, 0, 0);
		drain_and_rest();

		// Directed: zero-width x range, bin count of zero along x and an oversized one along y
		set_ranges(5, 5, -32768, 32767, 0, 127);
		wait_drained();
		push_req(REQ_INSERT, 5, -32768, 3, 0, 0);
		push_req(REQ_INSERT, 5, 32767, 3, 0, 0);
		push_req(REQ_INSERT, 4, 0, 3, 0, 0);
		push_req(REQ_INSERT, 6, 0, 3, 0, 0);
		push_req(REQ_READ, 0, 0, 0, 0, 63);
		drain_and_rest();

		// Directed: inverted x range rejects everything
		set_ranges(10, -10, -32768, 32767, 64, 64);
		wait_drained();
		push_req(REQ_INSERT, 0, 0, 9, 0, 0);
		push_req(REQ_INSERT, 10, 0, 9, 0, 0);
		push_req(REQ_INSERT, -10, 0, 9, 0, 0);
		drain_and_rest();

		// Full ranges and full bin counts: pile heavy weights onto one bin,
		// with neither side idling for the whole stretch
		steady = 1'b1;
		set_ranges(-32768, 32767, -32768, 32767, 64, 64);
		wait_drained();
		for (int i = 0; i < 64; i++)
			push_req(REQ_INSERT, 32767, -32768, 'hFFFF, 0, 0);
		push_req(REQ_READ, 0, 0, 0, 63, 0);
		drain_and_rest();
		steady = 1'b0;

		// Random settings, each followed by a burst of random requests
		for (int p = 0; p < 5; p++) begin
			random_setup(p % 3);
			wait_drained();
			for (int i = 0; i < 120; i++)
				req_queue.insert(req_queue.size(), random_request());
			drain_and_rest();
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("covered %0d inserts (%0d binned, %0d saturated), %0d reads, %0d clears, %0d void",
			n_insert, n_binned, n_saturated, n_read, n_clear, n_none);
		$display("%0d register writes across %0d settings", cfg_taken, n_settings);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/hist2_pkg.sv
rtl/hist2_cfg.sv
rtl/hist2_bin_map.sv
rtl/hist2_mem.sv
rtl/weighted_2d_histogram.sv
tb/sv/weighted_2d_histogram_test.sv
